// ----- sv/utf8_byte_stream_decoder_macros.svh -----
// ---------------------------------------------------------------------------
// utf8 byte stream decoder assertion macros
// concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define UTF8D_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8d assertion failed");

`define UTF8D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8d assertion failed");

`else

`define UTF8D_ASSERT_SAME(label, clk, rst, ante, cons)

`define UTF8D_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/utf8d_pkg.sv -----
// ---------------------------------------------------------------------------
// utf8d_pkg
// shared types, constants and helpers of the utf8 byte stream decoder
// ---------------------------------------------------------------------------
package utf8d_pkg;

   localparam int unsigned CodeWidth = 21;
   localparam int unsigned NarrowWidth = 16;

   localparam logic [7:0] LEAD2_BASE = 8'hC0;
   localparam logic [7:0] LEAD3_BASE = 8'hE0;
   localparam logic [7:0] LEAD4_BASE = 8'hF0;
   localparam logic [7:0] LEAD2_MASK = 8'h1F;
   localparam logic [7:0] LEAD3_MASK = 8'h0F;
   localparam logic [7:0] LEAD4_MASK = 8'h07;
   localparam logic [7:0] CONT_MASK = 8'h3F;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [CodeWidth-1:0] code_point;
      logic                 out_last;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      req_payload_type data;
   } item_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } result_type;

   function automatic logic [CodeWidth-1:0] finish_value(
      input logic [CodeWidth-1:0] value,
      input logic                 wide
   );
      logic [CodeWidth-1:0] result;
      result = value;
      if (!wide) begin
         result = {{(CodeWidth-NarrowWidth){1'b0}}, value[NarrowWidth-1:0]};
      end
      return result;
   endfunction

endpackage

// ----- sv/utf8d_in_stage.sv -----
// ---------------------------------------------------------------------------
// utf8d_in_stage
// input register, holds one byte until the decode step can take it
// ---------------------------------------------------------------------------
module utf8d_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  utf8d_pkg::req_payload_type req_data,
   input  logic                      space,
   output utf8d_pkg::item_type       item
);
   import utf8d_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type data_ff;

   assign req_stall = valid_ff && !space;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && !req_stall) begin
         data_ff <= req_data;
      end
   end

   assign item.valid = valid_ff && space;
   assign item.data  = data_ff;

endmodule

// ----- sv/utf8d_decode.sv -----
// ---------------------------------------------------------------------------
// utf8d_decode
// sequence state and one-byte decode step, pads a stream cut mid-sequence
// ---------------------------------------------------------------------------
`include "utf8_byte_stream_decoder_macros.svh"

module utf8d_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  utf8d_pkg::item_type   item,
   output utf8d_pkg::result_type result
);
   import utf8d_pkg::*;

   logic                 wide_ff;
   logic                 wide_in;
   logic [CodeWidth-1:0] partial_ff;
   logic [CodeWidth-1:0] partial_in;
   logic [1:0]           pending_ff;
   logic [1:0]           pending_in;
   logic [CodeWidth-1:0] acc_value;
   logic [CodeWidth-1:0] pad_value;
   logic [7:0]           b;
   logic                 emit;

   assign b = item.data.in_byte;
   assign wide_in = csr_wr_en ? csr_wr_data : wide_ff;

   always_comb begin
      partial_in = partial_ff;
      pending_in = pending_ff;
      acc_value  = '0;
      pad_value  = '0;
      emit       = 1'b0;
      result     = '0;
      if (item.valid) begin
         if (pending_ff == 2'd0) begin
            if (b inside {[8'h00:8'hBF]}) begin
               emit = 1'b1;
               result.data.code_point = finish_value({{(CodeWidth-8){1'b0}}, b}, wide_ff);
               result.data.out_last   = item.data.in_last;
            end else if (b < LEAD3_BASE) begin
               partial_in = {{(CodeWidth-8){1'b0}}, b & LEAD2_MASK};
               pending_in = 2'd1;
            end else if (b < LEAD4_BASE) begin
               partial_in = {{(CodeWidth-8){1'b0}}, b & LEAD3_MASK};
               pending_in = 2'd2;
            end else begin
               partial_in = {{(CodeWidth-8){1'b0}}, b & LEAD4_MASK};
               pending_in = 2'd3;
            end
         end else begin
            acc_value  = {partial_ff[CodeWidth-7:0], b[5:0] & CONT_MASK[5:0]};
            pending_in = pending_ff - 2'd1;
            partial_in = acc_value;
            if (pending_in == 2'd0) begin
               emit = 1'b1;
               result.data.code_point = finish_value(acc_value, wide_ff);
               result.data.out_last   = item.data.in_last;
               partial_in = '0;
            end
         end
         if (!emit && item.data.in_last) begin
            case (pending_in)
               2'd1:    pad_value = {partial_in[CodeWidth-7:0], 6'b0};
               2'd2:    pad_value = {partial_in[CodeWidth-13:0], 12'b0};
               2'd3:    pad_value = {partial_in[CodeWidth-19:0], 18'b0};
               default: pad_value = partial_in;
            endcase
            emit = 1'b1;
            result.data.code_point = finish_value(pad_value, wide_ff);
            result.data.out_last   = 1'b1;
            partial_in = '0;
            pending_in = 2'd0;
         end
      end
      result.valid = emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff    <= 1'b1;
         partial_ff <= '0;
         pending_ff <= 2'd0;
      end else begin
         wide_ff    <= wide_in;
         partial_ff <= partial_in;
         pending_ff <= pending_in;
      end
   end

   // a final byte always closes the stream with one result
   `UTF8D_ASSERT_SAME(a_last_gives_result, clock, reset,
      item.valid && item.data.in_last, result.valid && result.data.out_last)
   `UTF8D_ASSERT_NEXT(a_last_clears_state, clock, reset,
      item.valid && item.data.in_last, pending_ff == 2'd0 && partial_ff == '0)
   `UTF8D_ASSERT_SAME(a_no_result_idle, clock, reset,
      !item.valid, !result.valid)

endmodule

// ----- sv/utf8d_out_stage.sv -----
// ---------------------------------------------------------------------------
// utf8d_out_stage
// two-word result buffer, parts the decode step from the result stall
// ---------------------------------------------------------------------------
`include "utf8_byte_stream_decoder_macros.svh"

module utf8d_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  utf8d_pkg::result_type      result,
   output logic                       space,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output utf8d_pkg::rsp_payload_type rsp_data
);
   import utf8d_pkg::*;

   logic [1:0]      count_ff;
   logic [1:0]      count_in;
   rsp_payload_type head_ff;
   rsp_payload_type head_in;
   rsp_payload_type tail_ff;
   rsp_payload_type tail_in;
   logic            pop;

   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = head_ff;
   assign space     = count_ff != 2'd2;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case (count_ff)
         2'd0: begin
            if (result.valid) begin
               head_in  = result.data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (result.valid && pop) begin
               head_in = result.data;
            end else if (result.valid) begin
               tail_in  = result.data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in  = tail_ff;
               count_in = 2'd1;
            end
         end
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   `UTF8D_ASSERT_SAME(a_no_push_when_full, clock, reset,
      result.valid, count_ff != 2'd2)
   `UTF8D_ASSERT_NEXT(a_full_drains_to_one, clock, reset,
      count_ff == 2'd2 && pop, count_ff == 2'd1 && rsp_data == $past(tail_ff))
   `UTF8D_ASSERT_NEXT(a_single_drains_to_empty, clock, reset,
      count_ff == 2'd1 && pop && !result.valid, count_ff == 2'd0)

endmodule

// ----- sv/utf8_byte_stream_decoder.sv -----
// ---------------------------------------------------------------------------
// utf8_byte_stream_decoder
// utf8 byte stream to code points, one byte a cycle while req_stall is low, 16 or 21 bit results
//
//   channel   ports                         moves
//   req       req_valid req_stall req_data  one byte and its last flag
//   rsp       rsp_valid rsp_stall rsp_data  one code point and its last flag
//   csr       csr_wr_en csr_wr_data         wide_output bit, reset 1
//
// one byte is taken every cycle that req_stall is low; a result's byte passes
// the input register, then the decode step writes the result into the buffer
// the result buffer holds two words; an rsp stall fills it, and req then
// waits until the stall ends and the extra word drains
// req_stall rises only while the buffer is full and the input register busy
// synchronous reset clears the sequence state and sets wide_output
// ---------------------------------------------------------------------------
module utf8_byte_stream_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  utf8d_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output utf8d_pkg::rsp_payload_type rsp_data,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data
);
   import utf8d_pkg::*;

   item_type   item;
   result_type result;
   logic       space;

   utf8d_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .space     (space),
      .item      (item)
   );

   utf8d_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .result      (result)
   );

   utf8d_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
